[rtl/pfrt_pkg.sv]
// shared types, constants and sizes of the packet filter rule table
package pfrt_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  localparam int ADDR_W   = 64;
  localparam int PORT_W   = 16;
  localparam int ID_W     = 32;
  localparam int KIND_W   = 2;

  localparam int IN_DATA_W  = 120;
  localparam int OUT_DATA_W = 40;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD   = 2'd0,
    KIND_DEL   = 2'd1,
    KIND_CHECK = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  // one classified operation travelling from front to back
  typedef struct packed {
    logic              is_add;
    logic              is_del;
    logic              is_chk;
    logic [ADDR_W-1:0] address;
    logic [PORT_W-1:0] port_number;
    logic              allow_action;
    logic [ID_W-1:0]   target_id;
  } op_t;

endpackage

[rtl/packet_filter_rule_table_top.sv]
// top level of the packet filter rule table
// path: an input transfer reaches its result on the master side through
//   the front register, the queue, the table update and the result register
// throughput: one item per cycle unless results stall; the table compares all slots in parallel
// reset: asynchronous, active low; empties the table, queue and id counter
module packet_filter_rule_table_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // slave side: operations in
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // tdata: address [63:0], port_number [79:64], allow_action [80],
  // target_id [112:81], zero [119:113]
  input  logic [pfrt_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // tuser: kind [1:0]
  input  logic [pfrt_pkg::KIND_W-1:0]     s_axis_tuser_i,
  // master side: results out
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // tdata: status [0], new_id [32:1], zero [39:33]
  output logic [pfrt_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);

  // decoded operation leaving the front register
  pfrt_pkg::op_t fr_op;
  logic          fr_valid, fr_ready;

  // head of the queue feeding the table
  pfrt_pkg::op_t bk_op;
  logic          bk_valid, bk_ready;

  // front: takes transfers and sorts them into add, delete, check or none
  pfrt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_data_i  (s_axis_tdata_i),
    .in_kind_i  (s_axis_tuser_i),
    .op_valid_o (fr_valid),
    .op_ready_i (fr_ready),
    .op_o       (fr_op)
  );

  // queue decouples a stalled result side from the input side
  pfrt_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_op_i    (fr_op),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_op_o     (bk_op)
  );

  // back: applies the operation to the rule table and holds the result
  pfrt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (bk_valid),
    .op_ready_o  (bk_ready),
    .op_i        (bk_op),
    .res_valid_o (m_axis_tvalid_o),
    .res_ready_i (m_axis_tready_i),
    .res_data_o  (m_axis_tdata_o)
  );

endmodule

[rtl/pfrt_front.sv]
// front end: input transfer register and operation decode
module pfrt_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [pfrt_pkg::IN_DATA_W-1:0] in_data_i,
  input  logic [pfrt_pkg::KIND_W-1:0]    in_kind_i,
  output logic                           op_valid_o,
  input  logic                           op_ready_i,
  output pfrt_pkg::op_t                  op_o
);

  logic          valid_q, valid_d;
  pfrt_pkg::op_t op_q, op_d;

  assign in_ready_o = !valid_q || op_ready_i;
  assign op_valid_o = valid_q;
  assign op_o       = op_q;

  always_comb begin
    op_d              = op_q;
    op_d.address      = in_data_i[63:0];
    op_d.port_number  = in_data_i[79:64];
    op_d.allow_action = in_data_i[80];
    op_d.target_id    = in_data_i[112:81];
    op_d.is_add       = 1'b0;
    op_d.is_del       = 1'b0;
    op_d.is_chk       = 1'b0;
    unique case (pfrt_pkg::kind_e'(in_kind_i))
      pfrt_pkg::KIND_ADD:   op_d.is_add = 1'b1;
      pfrt_pkg::KIND_DEL:   op_d.is_del = 1'b1;
      pfrt_pkg::KIND_CHECK: op_d.is_chk = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end else if (op_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q <= op_d;
    end
  end

endmodule

[rtl/pfrt_queue.sv]
// short operation queue between front and back
module pfrt_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  pfrt_pkg::op_t push_op_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output pfrt_pkg::op_t pop_op_o
);

  pfrt_pkg::op_t                   mem_q [pfrt_pkg::QUEUE_DEPTH];
  logic [pfrt_pkg::QPTR_W-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [pfrt_pkg::QCNT_W-1:0]     cnt_q, cnt_d;
  logic                            push, pop;

  assign push_ready_o = (cnt_q != pfrt_pkg::QCNT_W'(pfrt_pkg::QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_op_o     = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == pfrt_pkg::QPTR_W'(pfrt_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == pfrt_pkg::QPTR_W'(pfrt_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_op_i;
    end
  end

endmodule

[rtl/pfrt_back.sv]
// back end: rule table, parallel match and result register
module pfrt_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            op_valid_i,
  output logic                            op_ready_o,
  input  pfrt_pkg::op_t                   op_i,
  output logic                            res_valid_o,
  input  logic                            res_ready_i,
  output logic [pfrt_pkg::OUT_DATA_W-1:0] res_data_o
);

  localparam int D = pfrt_pkg::TABLE_DEPTH;

  logic                        valid_q [D];
  logic [pfrt_pkg::ID_W-1:0]   id_q    [D];
  logic [pfrt_pkg::ADDR_W-1:0] addr_q  [D];
  logic [pfrt_pkg::PORT_W-1:0] port_q  [D];
  logic                        allow_q [D];
  logic [pfrt_pkg::ID_W-1:0]   id_cnt_q, id_next;

  logic                        out_valid_q;
  logic                        status_q, status_d;
  logic [pfrt_pkg::ID_W-1:0]   new_id_q, new_id_d;

  logic                        take;
  logic                        free_hit, del_hit, chk_hit, chk_allow;
  logic [pfrt_pkg::IDX_W-1:0]  free_idx, del_idx;

  assign op_ready_o  = !out_valid_q || res_ready_i;
  assign take        = op_valid_i && op_ready_o;
  assign res_valid_o = out_valid_q;
  assign res_data_o  = {7'd0, new_id_q, status_q};
  assign id_next     = id_cnt_q + 1'b1;

  // lowest free slot, lowest slot with the id, lowest matching slot
  always_comb begin
    free_hit  = 1'b0;
    del_hit   = 1'b0;
    chk_hit   = 1'b0;
    chk_allow = 1'b0;
    free_idx  = '0;
    del_idx   = '0;
    for (int i = D - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_hit = 1'b1;
        free_idx = pfrt_pkg::IDX_W'(i);
      end
      if (valid_q[i] && id_q[i] == op_i.target_id) begin
        del_hit = 1'b1;
        del_idx = pfrt_pkg::IDX_W'(i);
      end
      if (valid_q[i] && addr_q[i] == op_i.address && port_q[i] == op_i.port_number) begin
        chk_hit   = 1'b1;
        chk_allow = allow_q[i];
      end
    end
  end

  always_comb begin
    status_d = 1'b1;
    new_id_d = '0;
    if (op_i.is_add && free_hit) begin
      status_d = 1'b0;
      new_id_d = id_next;
    end else if (op_i.is_del && del_hit) begin
      status_d = 1'b0;
    end else if (op_i.is_chk && chk_hit) begin
      status_d = !chk_allow;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      id_cnt_q    <= '0;
      for (int i = 0; i < D; i++) begin
        valid_q[i] <= 1'b0;
        id_q[i]    <= '0;
      end
    end else begin
      if (take) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (take && op_i.is_add && free_hit) begin
        id_cnt_q          <= id_next;
        valid_q[free_idx] <= 1'b1;
        id_q[free_idx]    <= id_next;
      end
      if (take && op_i.is_del && del_hit) begin
        valid_q[del_idx] <= 1'b0;
        id_q[del_idx]    <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      status_q <= status_d;
      new_id_q <= new_id_d;
    end
    if (take && op_i.is_add && free_hit) begin
      addr_q[free_idx]  <= op_i.address;
      port_q[free_idx]  <= op_i.port_number;
      allow_q[free_idx] <= op_i.allow_action;
    end
  end

endmodule

[rtl/pfrt_checker.sv]
// port-level checks on the rule table top, bound to it
module pfrt_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [pfrt_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);

  // a result waiting on the master side holds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // padding bits stay zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[39:33] == 7'd0)
    else $error("result padding not zero");

  // a failed or denied result never carries an id
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[0] |-> m_axis_tdata_o[32:1] == 32'd0)
    else $error("failure result carries an id");

  // no result straight out of reset
  assert property (@(posedge clk_i)
    !$past(rst_ni) |-> !m_axis_tvalid_o)
    else $error("result valid after reset");

endmodule

bind packet_filter_rule_table_top pfrt_checker u_pfrt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
